FILE: rtl/core/swsu_pkg.sv
// Shared types and constants for the shell word splitter.
package swsu_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned COUNT_W     = 2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOW  = 1'b1;

  typedef struct packed {
    logic dq;
    logic sq;
    logic esc;
    logic word_open;
  } split_state_t;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
  } result_t;

  // Results caused by one item, in emission order starting at res[0].
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

endpackage

FILE: rtl/core/shell_word_splitter_unit.sv
// Top level of the shell word splitter: input register, decode step and result register.
//
// The block takes a command line one character per item and splits it into words the
// way a shell does: space, tab and newline separate words outside quotes, single and
// double quotes group text and are dropped, and a backslash escapes the next character
// (inside double quotes only a backslash or a double quote; before anything else the
// backslash is kept). Each result item is either a word character (tuser 0, tdata the
// character) or an end-of-word mark (tuser 1, tdata 0); tlast flags the final result
// caused by an input item. An input item with tlast set ends the line: an open word is
// closed and all quote state returns to its reset value. Items flow through an input
// register, combinational decode logic and a result register, so an item is taken every
// cycle as long as each item causes at most one result and m_tready is high. An item that
// causes two or three results holds the result register, which hands out one result per
// cycle while m_tready is high, until its last result is taken; an item that causes none
// retires without waiting on the result register. While a result waits on the output, the
// input register still takes one more item and items that cause no result keep retiring;
// an item with results then holds the input until the last waiting result is handed out.
module shell_word_splitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swsu_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] in_char
  input  logic                          s_tlast,   // end_of_text
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swsu_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] out_char
  output logic                          m_tuser,   // [0] kind
  output logic                          m_tlast    // last
);

  // Input register.
  logic                          in_valid;
  logic [swsu_pkg::CHAR_W-1:0]   in_char;
  logic                          in_eot;

  // Quote and escape state, updated when an item leaves the input register.
  swsu_pkg::split_state_t st;
  swsu_pkg::split_state_t st_next;
  swsu_pkg::bundle_t      bundle;

  logic emit_free;
  logic advance;
  logic load;

  swsu_decode u_decode (
    .st      (st),
    .c       (in_char),
    .eot     (in_eot),
    .st_next (st_next),
    .bundle  (bundle)
  );

  // An item with no results retires without touching the result register.
  assign advance  = in_valid && ((bundle.count == '0) || emit_free);
  assign load     = advance && (bundle.count != '0);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  swsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .free     (emit_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/core/swsu_decode.sv
// Combinational step: one character, its end-of-line flag and the quote state give the results and next state.
module swsu_decode (
  input  swsu_pkg::split_state_t        st,
  input  logic [swsu_pkg::CHAR_W-1:0]   c,
  input  logic                          eot,
  output swsu_pkg::split_state_t        st_next,
  output swsu_pkg::bundle_t             bundle
);

  logic [swsu_pkg::COUNT_W-1:0] n;
  logic                         is_sep;

  assign is_sep = (c == swsu_pkg::CH_SPACE) || (c == swsu_pkg::CH_TAB) ||
                  (c == swsu_pkg::CH_NL);

  always_comb begin
    st_next = st;
    bundle  = '0;
    n       = '0;
    if (st.esc) begin
      st_next.esc = 1'b0;
      if (st.dq && (c != swsu_pkg::CH_BSLASH) && (c != swsu_pkg::CH_DQUOTE)) begin
        // Inside double quotes the backslash survives before other characters.
        bundle.res[0] = '{kind: swsu_pkg::KIND_CHAR, ch: swsu_pkg::CH_BSLASH};
        bundle.res[1] = '{kind: swsu_pkg::KIND_CHAR, ch: c};
        n = 2'd2;
      end else begin
        bundle.res[0] = '{kind: swsu_pkg::KIND_CHAR, ch: c};
        n = 2'd1;
      end
      st_next.word_open = 1'b1;
    end else if (st.sq) begin
      if (c == swsu_pkg::CH_SQUOTE) begin
        st_next.sq = 1'b0;
      end else begin
        bundle.res[0] = '{kind: swsu_pkg::KIND_CHAR, ch: c};
        n = 2'd1;
      end
    end else if (st.dq) begin
      if (c == swsu_pkg::CH_DQUOTE) begin
        st_next.dq = 1'b0;
      end else if (c == swsu_pkg::CH_BSLASH) begin
        st_next.esc = 1'b1;
      end else begin
        bundle.res[0] = '{kind: swsu_pkg::KIND_CHAR, ch: c};
        n = 2'd1;
      end
    end else if (c == swsu_pkg::CH_DQUOTE) begin
      st_next.dq        = 1'b1;
      st_next.word_open = 1'b1;
    end else if (c == swsu_pkg::CH_SQUOTE) begin
      st_next.sq        = 1'b1;
      st_next.word_open = 1'b1;
    end else if (c == swsu_pkg::CH_BSLASH) begin
      st_next.esc       = 1'b1;
      st_next.word_open = 1'b1;
    end else if (is_sep) begin
      if (st.word_open) begin
        bundle.res[0] = '{kind: swsu_pkg::KIND_EOW, ch: '0};
        n = 2'd1;
        st_next.word_open = 1'b0;
      end
    end else begin
      bundle.res[0] = '{kind: swsu_pkg::KIND_CHAR, ch: c};
      n = 2'd1;
      st_next.word_open = 1'b1;
    end

    if (eot) begin
      if (st_next.word_open) begin
        bundle.res[n] = '{kind: swsu_pkg::KIND_EOW, ch: '0};
        n = n + 2'd1;
      end
      st_next = '0;
    end
    bundle.count = n;
  end

endmodule

FILE: rtl/core/swsu_emit.sv
// Result register that hands out the results of one item, one per cycle while m_tready is high.
module swsu_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  swsu_pkg::bundle_t             bundle,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swsu_pkg::CHAR_W-1:0]   m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  logic                         busy;
  logic [swsu_pkg::COUNT_W-1:0] idx;
  swsu_pkg::bundle_t            held;
  swsu_pkg::result_t            cur;
  logic                         at_last;

  assign at_last = (idx == (held.count - 2'd1));
  assign free    = !busy || (m_tready && at_last);

  always_comb begin
    case (idx)
      2'd0:    cur = held.res[0];
      2'd1:    cur = held.res[1];
      default: cur = held.res[2];
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = cur.ch;
  assign m_tuser  = cur.kind;
  assign m_tlast  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

endmodule

FILE: rtl/core/swsu_checker.sv
// Port-level checks for the shell word splitter, bound to the top level.
module swsu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [swsu_pkg::CHAR_W-1:0]   s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [swsu_pkg::CHAR_W-1:0]   m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // An end-of-word mark carries no character.
  a_eow_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == swsu_pkg::KIND_EOW) |-> (m_tdata == '0))
    else $error("end-of-word result with nonzero data");

  // Nothing an item causes follows its end-of-word mark.
  a_eow_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == swsu_pkg::KIND_EOW) |-> m_tlast)
    else $error("end-of-word result not last of its item");

  // No result shows in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind shell_word_splitter_unit swsu_checker u_swsu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
